// ===== sv/last_k_product_stream_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LAST_K_PRODUCT_STREAM_CORE_ASSERT_SVH
`define LAST_K_PRODUCT_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, dropped while reset is held.
`define LKP_ASSERT_IMP(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, dropped while reset is held.
`define LKP_ASSERT_NXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lkp_pkg.sv =====
package lkp_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RUN_W  = $clog2(DEPTH + 2);
  localparam int VAL_W  = 32;
  localparam int K_W    = 10;
  localparam int PROD_W = 64;
  localparam int HALF_W = PROD_W / 2;
  localparam int CNT_W  = $clog2(PROD_W);
  localparam int IDX_W  = ((ADDR_W > K_W) ? ADDR_W : K_W) + 2;
  localparam int CMP_W  = (K_W > RUN_W) ? K_W : RUN_W;

  localparam logic [PROD_W-1:0] SIGN_BIT = {1'b1, {(PROD_W-1){1'b0}}};
  localparam logic [PROD_W-1:0] MAX_POS  = {1'b0, {(PROD_W-1){1'b1}}};
  localparam logic [PROD_W-1:0] ONE      = {{(PROD_W-1){1'b0}}, 1'b1};

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_QUERY = 1'b1
  } lkp_op_t;

  typedef struct packed {
    lkp_op_t                   op;
    logic signed [VAL_W-1:0]   value;
    logic        [K_W-1:0]     window_length;
  } lkp_in_t;

  typedef struct packed {
    logic signed [PROD_W-1:0]  product;
    logic                      overflow;
  } lkp_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_MUL_FIN,
    ST_Q_RD,
    ST_DIV,
    ST_Q_FIN
  } lkp_state_t;

  // How a query is answered, decided when it is taken.
  typedef enum logic [1:0] {
    QK_DIV_ONE,
    QK_DIV_RING,
    QK_ZERO,
    QK_OVF
  } lkp_qkind_t;

endpackage

// ===== sv/lkp_ram.sv =====
module lkp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/last_k_product_stream_core.sv =====
// Channel  | Ports                 | Transfer
// ---------+-----------------------+------------------------------------------
// input    | start, busy, in_item  | rising edge with start high, busy low
// result   | out_valid, out_item   | one-cycle strobe, one per query item
//
// A zero add needs no multiply; a nonzero add forms two 32x32 partial products on one
// shared multiplier, then sum and range check. A query reads the ring, then runs
// 64 steps of a radix-2 restoring divider; a query that needs no division strobes
// straight from the ring read.
// Reset: synchronous, rst_n low; the prefix ring needs no clearing pass.
// The receiver cannot stall; results are never held back.
module last_k_product_stream_core
  import lkp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lkp_in_t  in_item,
  output logic     out_valid,
  output lkp_out_t out_item
);

  lkp_state_t state_r, state_nxt;

  logic [PROD_W-1:0] latest_r, latest_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic              sticky_r, sticky_nxt;
  logic              out_valid_r, out_valid_nxt;
  lkp_out_t          out_item_r, out_item_nxt;

  logic [PROD_W-1:0] mag_a_r, mag_a_nxt;
  logic [VAL_W-1:0]  mag_b_r, mag_b_nxt;
  logic              neg_r, neg_nxt;
  logic [PROD_W-1:0] lo_r, lo_nxt;
  logic [PROD_W-1:0] hi_r, hi_nxt;
  logic [PROD_W-1:0] sum_r, sum_nxt;
  logic              sum_ovf_r, sum_ovf_nxt;
  lkp_qkind_t        qkind_r, qkind_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] div_r, div_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // datapath
  logic [PROD_W-1:0] mag_prefix;
  logic [VAL_W-1:0]  val_bits;
  logic [VAL_W-1:0]  mag_val;
  logic [HALF_W-1:0] mul_a;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W:0]   sum_full;
  logic              sum_ovf;
  logic              fin_ovf;
  logic [PROD_W-1:0] fin_prefix;
  logic [PROD_W-1:0] den;
  logic [PROD_W-1:0] mag_den;
  logic [PROD_W:0]   div_sh;
  logic [PROD_W:0]   div_diff;
  logic              div_ge;
  logic [IDX_W-1:0]  idx_raw;
  logic [IDX_W-1:0]  idx_mod;
  logic [CMP_W-1:0]  k_c;
  logic [CMP_W-1:0]  run_c;
  logic              ram_we;
  logic [PROD_W-1:0] ram_rdata;

  assign mag_prefix = latest_r[PROD_W-1] ? (PROD_W'(0) - latest_r) : latest_r;
  assign val_bits   = in_item.value;
  assign mag_val    = val_bits[VAL_W-1] ? (VAL_W'(0) - val_bits) : val_bits;

  // one shared 32x32 multiplier: low half of the prefix, then high half
  assign mul_a    = (state_r == ST_MUL_LO) ? mag_a_r[HALF_W-1:0] : mag_a_r[PROD_W-1:HALF_W];
  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mag_b_r);
  assign sum_full = {1'b0, hi_r[HALF_W-1:0], {HALF_W{1'b0}}} + {1'b0, lo_r};
  assign sum_ovf  = (|hi_r[PROD_W-1:HALF_W]) | sum_full[PROD_W];

  assign fin_ovf    = sum_ovf_r | (sum_r > (neg_r ? SIGN_BIT : MAX_POS));
  assign fin_prefix = fin_ovf ? '0 : (neg_r ? (PROD_W'(0) - sum_r) : sum_r);

  assign den     = (qkind_r == QK_DIV_ONE) ? ONE : ram_rdata;
  assign mag_den = den[PROD_W-1] ? (PROD_W'(0) - den) : den;

  assign div_sh   = {rem_r, quo_r[PROD_W-1]};
  assign div_ge   = div_sh >= {1'b0, div_r};
  assign div_diff = div_sh - {1'b0, div_r};

  // ring slot k values behind the latest prefix
  assign idx_raw = IDX_W'(head_r) + IDX_W'(DEPTH - 1) - IDX_W'(in_item.window_length);
  assign idx_mod = (idx_raw >= IDX_W'(DEPTH)) ? (idx_raw - IDX_W'(DEPTH)) : idx_raw;

  assign k_c   = CMP_W'(in_item.window_length);
  assign run_c = CMP_W'(run_r);

  assign ram_we = (state_r == ST_MUL_FIN);

  lkp_ram #(
    .WIDTH (PROD_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (fin_prefix),
    .raddr (idx_mod[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    latest_nxt    = latest_r;
    head_nxt      = head_r;
    run_nxt       = run_r;
    sticky_nxt    = sticky_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mag_a_nxt     = mag_a_r;
    mag_b_nxt     = mag_b_r;
    neg_nxt       = neg_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    sum_ovf_nxt   = sum_ovf_r;
    qkind_nxt     = qkind_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    div_nxt       = div_r;
    cnt_nxt       = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_item.op == OP_ADD) begin
            if (val_bits == '0) begin
              // restart the run
              latest_nxt = ONE;
              run_nxt    = '0;
              sticky_nxt = 1'b0;
            end else begin
              mag_a_nxt = mag_prefix;
              mag_b_nxt = mag_val;
              neg_nxt   = latest_r[PROD_W-1] ^ val_bits[VAL_W-1];
              state_nxt = ST_MUL_LO;
            end
          end else begin
            if (sticky_r) begin
              qkind_nxt = QK_OVF;
            end else if (k_c > run_c) begin
              qkind_nxt = QK_ZERO;
            end else if ((k_c == run_c) && (run_r <= RUN_W'(DEPTH))) begin
              qkind_nxt = QK_DIV_ONE;
            end else if (k_c < CMP_W'(DEPTH)) begin
              qkind_nxt = QK_DIV_RING;
            end else begin
              qkind_nxt = QK_ZERO;
            end
            state_nxt = ST_Q_RD;
          end
        end
      end

      ST_MUL_LO: begin
        lo_nxt    = mul_p;
        state_nxt = ST_MUL_HI;
      end

      ST_MUL_HI: begin
        hi_nxt    = mul_p;
        state_nxt = ST_MUL_SUM;
      end

      ST_MUL_SUM: begin
        sum_nxt     = sum_full[PROD_W-1:0];
        sum_ovf_nxt = sum_ovf;
        state_nxt   = ST_MUL_FIN;
      end

      ST_MUL_FIN: begin
        // ring write of fin_prefix at head_r happens this cycle
        latest_nxt = fin_prefix;
        sticky_nxt = sticky_r | fin_ovf;
        head_nxt   = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : (head_r + ADDR_W'(1));
        if (run_r <= RUN_W'(DEPTH)) begin
          run_nxt = run_r + RUN_W'(1);
        end
        state_nxt = ST_IDLE;
      end

      ST_Q_RD: begin
        if (qkind_r == QK_OVF) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.product  = '0;
          out_item_nxt.overflow = 1'b1;
          state_nxt             = ST_IDLE;
        end else if ((qkind_r == QK_ZERO) || (mag_den == '0)) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.product  = '0;
          out_item_nxt.overflow = 1'b0;
          state_nxt             = ST_IDLE;
        end else begin
          neg_nxt   = latest_r[PROD_W-1] ^ den[PROD_W-1];
          quo_nxt   = mag_prefix;
          rem_nxt   = '0;
          div_nxt   = mag_den;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = div_ge ? div_diff[PROD_W-1:0] : div_sh[PROD_W-1:0];
        quo_nxt = {quo_r[PROD_W-2:0], div_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(PROD_W - 1)) begin
          state_nxt = ST_Q_FIN;
        end
      end

      ST_Q_FIN: begin
        out_valid_nxt = 1'b1;
        if (!neg_r && quo_r[PROD_W-1]) begin
          // positive quotient of 2^63 does not fit
          out_item_nxt.product  = '0;
          out_item_nxt.overflow = 1'b1;
        end else begin
          out_item_nxt.product  = neg_r ? (PROD_W'(0) - quo_r) : quo_r;
          out_item_nxt.overflow = 1'b0;
        end
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      latest_r    <= ONE;
      head_r      <= '0;
      run_r       <= '0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latest_r    <= latest_nxt;
      head_r      <= head_nxt;
      run_r       <= run_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    mag_a_r    <= mag_a_nxt;
    mag_b_r    <= mag_b_nxt;
    neg_r      <= neg_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sum_r      <= sum_nxt;
    sum_ovf_r  <= sum_ovf_nxt;
    qkind_r    <= qkind_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    div_r      <= div_nxt;
    cnt_r      <= cnt_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== sv/lkp_checker.sv =====
`include "last_k_product_stream_core_assert.svh"

module lkp_checker
  import lkp_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input lkp_in_t  in_item,
  input logic     out_valid,
  input lkp_out_t out_item
);

  logic work_taken;
  logic ovf_result;
  logic zero_product;

  // only a zero add completes in its transfer cycle
  assign work_taken   = start && !busy && !(in_item.op == OP_ADD && in_item.value == '0);
  assign ovf_result   = out_valid && out_item.overflow;
  assign zero_product = (out_item.product == '0);

  // every query passes through the ring-read state before its strobe, so strobes never touch
  `LKP_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "strobe held too long")

  `LKP_ASSERT_NXT(a_busy_after_work, clk, rst_n, work_taken, busy, "busy not raised")

  `LKP_ASSERT_IMP(a_ovf_zero, clk, rst_n, ovf_result, zero_product, "overflow, nonzero product")

  // a result appears as the sequencer returns to idle
  `LKP_ASSERT_IMP(a_strobe_at_end, clk, rst_n, out_valid, $fell(busy), "strobe without end of work")

endmodule

bind last_k_product_stream_core lkp_checker u_lkp_checker (.*);

// ===== tb/last_k_product_stream_core_test.sv =====
`timescale 1ns / 1ps

module last_k_product_stream_core_test;
  import lkp_pkg::*;

  class product_scoreboard;
    logic signed [PROD_W-1:0] latest;
    logic signed [PROD_W-1:0] prefixes [DEPTH];
    int unsigned              head;
    int unsigned              run_len;
    bit                       sticky;
    lkp_out_t                 expected_q [$];
    int                       mismatches;
    int                       adds;
    int                       queries;
    int                       overflow_answers;

    function new();
      latest           = ONE;
      head             = 0;
      run_len          = 0;
      sticky           = 0;
      mismatches       = 0;
      adds             = 0;
      queries          = 0;
      overflow_answers = 0;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] %s", $time, msg);
    endtask

    // Update the prefix state for an accepted transfer; queue the answer of a query.
    function void note_input(lkp_in_t it);
      logic signed [2*PROD_W-1:0] lhs;
      logic signed [2*PROD_W-1:0] rhs;
      logic signed [2*PROD_W-1:0] wide;
      logic        [PROD_W-1:0]   den;
      logic        [PROD_W-1:0]   mag_n;
      logic        [PROD_W-1:0]   mag_d;
      logic        [PROD_W-1:0]   quot;
      lkp_out_t                   ans;
      int unsigned                k;
      bit                         neg;
      if (it.op == OP_ADD) begin
        adds++;
        if (it.value == 0) begin
          latest  = ONE;
          run_len = 0;
          sticky  = 0;
          return;
        end
        lhs  = (2*PROD_W)'(latest);
        rhs  = (2*PROD_W)'(it.value);
        wide = lhs * rhs;
        if (wide[2*PROD_W-1:PROD_W-1] != {(PROD_W+1){wide[PROD_W-1]}}) begin
          // out of range: the prefix is lost until the next zero
          sticky = 1;
          latest = '0;
        end else begin
          latest = wide[PROD_W-1:0];
        end
        prefixes[head] = latest;
        head = (head + 1) % DEPTH;
        if (run_len <= DEPTH) run_len++;
        return;
      end
      queries++;
      k   = it.window_length;
      ans = '0;
      if (sticky) begin
        ans.overflow = 1'b1;
      end else if (k <= run_len) begin
        if (k == run_len && run_len <= DEPTH) den = ONE;
        else if (k < DEPTH) den = prefixes[(head + DEPTH - 1 - k) % DEPTH];
        else den = '0;
        if (den != '0) begin
          neg   = latest[PROD_W-1] ^ den[PROD_W-1];
          mag_n = latest[PROD_W-1] ? ('0 - latest) : latest;
          mag_d = den[PROD_W-1] ? ('0 - den) : den;
          quot  = mag_n / mag_d;
          if (!neg && quot[PROD_W-1]) ans.overflow = 1'b1;
          else ans.product = neg ? ('0 - quot) : quot;
        end
      end
      expected_q.insert(expected_q.size(), ans);
    endfunction

    task check_result(lkp_out_t got);
      lkp_out_t want;
      if (got.overflow) overflow_answers++;
      if (expected_q.size() == 0) begin
        report_mismatch("result strobe with no query outstanding");
        return;
      end
      want = expected_q.pop_front();
      if (got.product !== want.product)
        report_mismatch($sformatf("product %0d, expected %0d", got.product, want.product));
      if (got.overflow !== want.overflow)
        report_mismatch($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
    endtask

    task flush_leftover();
      while (expected_q.size() != 0) begin
        void'(expected_q.pop_front());
        report_mismatch("query answer never arrived");
      end
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  lkp_in_t  in_item;
  logic     out_valid;
  lkp_out_t out_item;

  product_scoreboard sb;
  int                items_sent;
  bit                no_gaps;

  last_k_product_stream_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  // Hold start across back-to-back transfers; drop it only for a real gap.
  task automatic send_item(lkp_op_t op, logic [VAL_W-1:0] v, logic [K_W-1:0] k);
    lkp_in_t it;
    int      gap;
    it.op            = op;
    it.value         = v;
    it.window_length = k;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic add_value(logic [VAL_W-1:0] v);
    send_item(OP_ADD, v, K_W'($urandom));
  endtask

  task automatic ask(logic [K_W-1:0] k);
    send_item(OP_QUERY, $urandom, k);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 7) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (r < 65) v = $urandom_range(1, 4);
    else if (r < 88) v = $urandom_range(1, 1000);
    else return $urandom;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [K_W-1:0] pick_window();
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (sb.run_len + 1 > 1023) ? 1023 : sb.run_len + 1;
    if (r < 50) return K_W'($urandom_range(0, top));
    if (r < 80) return K_W'($urandom_range(0, 15));
    return K_W'($urandom_range(0, 1023));
  endfunction

  task automatic run_directed();
    ask(0);
    ask(1);
    add_value(3);
    add_value(-5);
    add_value(7);
    ask(1);
    ask(2);
    ask(3);
    ask(4);
    add_value(32'h8000_0000);
    ask(2);
    // window product of exactly 2^63 cannot be returned
    add_value(0);
    add_value(-1);
    add_value(32'h8000_0000);
    add_value(32'h8000_0000);
    add_value(2);
    ask(3);
    ask(4);
    // sticky overflow, then clear it with a zero
    add_value(0);
    add_value(32'h7FFF_FFFF);
    add_value(32'h7FFF_FFFF);
    add_value(32'h7FFF_FFFF);
    ask(1);
    add_value(5);
    ask(0);
    add_value(0);
    ask(1023);
    ask(0);
  endtask

  task automatic random_sequence();
    int len;
    no_gaps = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) != 0) add_value('0);
    len = $urandom_range(1, 40);
    repeat (len) begin
      if ($urandom_range(0, 99) < 65) add_value(pick_value());
      else ask(pick_window());
    end
  endtask

  // One run past the ring depth: wrap the head and saturate the run length.
  task automatic long_run();
    int          doubles;
    logic [31:0] v;
    doubles = 0;
    no_gaps = 1'b0;
    add_value('0);
    for (int i = 0; i < DEPTH + 16; i++) begin
      v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
      if (doubles < 40 && $urandom_range(0, 49) == 0) begin
        v = v << 1;
        doubles++;
      end
      add_value(v);
      if ($urandom_range(0, 31) == 0)
        ask(K_W'($urandom_range(0, 1) ? $urandom_range(1000, 1023) : $urandom_range(0, 1023)));
    end
    ask(1023);
    ask(1022);
    ask(0);
  endtask

  initial begin
    int  base;
    int  guard;
    bit  long_done;
    sb         = new();
    items_sent = 0;
    no_gaps    = 1'b0;
    long_done  = 1'b0;
    start      = 1'b0;
    in_item    = '0;
    rst_n      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    base = items_sent;
    while (items_sent - base < 1100) begin
      if (!long_done && items_sent - base > 60) begin
        long_run();
        long_done = 1'b1;
      end else begin
        random_sequence();
      end
    end
    @(negedge clk);
    start <= 1'b0;

    guard = 0;
    while (sb.expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
    sb.flush_leftover();

    $display("Sent %0d transfers: %0d adds, %0d queries, %0d answers with overflow set.",
             items_sent, sb.adds, sb.queries, sb.overflow_answers);
    $display("Runs covered restarts, sticky overflow and a ring wrap past %0d slots.", DEPTH);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lkp_pkg.sv
sv/lkp_ram.sv
sv/last_k_product_stream_core.sv
sv/lkp_checker.sv
tb/last_k_product_stream_core_test.sv
